>>> hw/rtl/nsc_pkg.sv
package nsc_pkg;

    localparam int ADDR_MAX   = 5;
    localparam int OUT_DATA_W = 40;

    // Characters of the sentence grammar
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Report status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_FRAMING  = 2'd2;
    localparam logic [1:0] ST_UNKNOWN  = 2'd3;

    // Sentence kinds
    localparam logic [3:0] KIND_NONE    = 4'd0;
    localparam logic [3:0] KIND_GGA     = 4'd1;
    localparam logic [3:0] KIND_GLL     = 4'd2;
    localparam logic [3:0] KIND_GSA     = 4'd3;
    localparam logic [3:0] KIND_GSV     = 4'd4;
    localparam logic [3:0] KIND_RMC     = 4'd5;
    localparam logic [3:0] KIND_VTG     = 4'd6;
    localparam logic [3:0] KIND_ZDA     = 4'd7;
    localparam logic [3:0] KIND_STI_PPS = 4'd8;
    localparam logic [3:0] KIND_STI_SNS = 4'd9;

    // Address and leading-field bookkeeping of the sentence in progress
    typedef struct packed {
        logic [ADDR_MAX-1:0][7:0] chars;
        logic [2:0]               count;   // 6 marks an overlong address
        logic                     f1_set;
        logic                     f1_bad;
        logic                     f2_set;
        logic                     f2_bad;
        logic [3:0]               f1_val;
        logic [3:0]               f2_val;
    } sent_info_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] kind;
        logic [7:0] talker_first;
        logic [7:0] talker_second;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } result_t;

endpackage

>>> hw/rtl/nsc_classify.sv
module nsc_classify
    import nsc_pkg::*;
(
    input  sent_info_t info,
    output logic [3:0] kind
);

    localparam logic [23:0] TYPE_GGA = "GGA";
    localparam logic [23:0] TYPE_GLL = "GLL";
    localparam logic [23:0] TYPE_GSA = "GSA";
    localparam logic [23:0] TYPE_GSV = "GSV";
    localparam logic [23:0] TYPE_RMC = "RMC";
    localparam logic [23:0] TYPE_VTG = "VTG";
    localparam logic [23:0] TYPE_ZDA = "ZDA";
    localparam logic [23:0] TYPE_STI = "STI";
    localparam logic [15:0] TALK_GP  = "GP";
    localparam logic [15:0] TALK_GN  = "GN";
    localparam logic [15:0] TALK_BD  = "BD";
    localparam logic [15:0] TALK_GL  = "GL";
    localparam logic [7:0]  TALK_P   = "P";

    logic        len4;
    logic        len5;
    logic        len_ok;
    logic [23:0] type_sel;
    logic [15:0] talk_sel;
    logic        gp, gn, bd, gl;
    logic        f1ok, f2ok;
    logic        is_sti;

    always_comb
    begin
        len4     = (info.count == 3'd4);
        len5     = (info.count == 3'd5);
        len_ok   = len4 || len5;
        // type is the last three address characters
        type_sel = len4 ? {info.chars[1], info.chars[2], info.chars[3]}
                        : {info.chars[2], info.chars[3], info.chars[4]};
        talk_sel = {info.chars[0], info.chars[1]};
        gp       = len5 && (talk_sel == TALK_GP);
        gn       = len5 && (talk_sel == TALK_GN);
        bd       = len5 && (talk_sel == TALK_BD);
        gl       = len5 && (talk_sel == TALK_GL);
        f1ok     = info.f1_set && !info.f1_bad;
        f2ok     = info.f2_set && !info.f2_bad;
        is_sti   = len4 && (type_sel == TYPE_STI) && (info.chars[0] == TALK_P);

        priority if (len_ok && type_sel == TYPE_GGA && (gp || gn))
            kind = KIND_GGA;
        else if (len_ok && type_sel == TYPE_GLL && (gp || gn))
            kind = KIND_GLL;
        else if (len_ok && type_sel == TYPE_GSA && (gp || gn || bd || gl))
            kind = KIND_GSA;
        else if (len_ok && type_sel == TYPE_GSV && (gp || bd || gl))
            kind = KIND_GSV;
        else if (len_ok && type_sel == TYPE_RMC && (gp || gn))
            kind = KIND_RMC;
        else if (len_ok && type_sel == TYPE_VTG && (gp || gn))
            kind = KIND_VTG;
        else if (len_ok && type_sel == TYPE_ZDA && (gp || gn))
            kind = KIND_ZDA;
        else if (is_sti && f1ok && info.f1_val == 4'd1)
            kind = KIND_STI_PPS;
        else if (is_sti && f1ok && info.f1_val == 4'd4 && f2ok && info.f2_val == 4'd1)
            kind = KIND_STI_SNS;
        else
            kind = KIND_NONE;
    end

endmodule

>>> hw/rtl/nsc_parser.sv
module nsc_parser
    import nsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [7:0]  char_in,
    output logic        res_valid,
    output result_t     res
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_ADDR = 3'd1;
    localparam logic [2:0] PH_BODY = 3'd2;
    localparam logic [2:0] PH_HEX1 = 3'd3;
    localparam logic [2:0] PH_HEX2 = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  hex_reg, hex_next;
    logic [1:0]  fnum_reg, fnum_next;
    sent_info_t  info_reg, info_next;

    logic [3:0]  kind;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic        is_digit;
    logic [7:0]  rsum;
    logic [7:0]  t1, t2;
    logic [3:0]  fval;
    logic        fbad;
    logic [7:0]  nv;

    nsc_classify u_classify (
        .info (info_reg),
        .kind (kind)
    );

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = char_in[3:0];
        if (char_in >= CH_ZERO && char_in <= CH_NINE)
            hex_val = char_in[3:0];
        else if ((char_in >= "A" && char_in <= "F") || (char_in >= "a" && char_in <= "f"))
            hex_val = char_in[3:0] + 4'd9;
        else
            hex_ok = 1'b0;
    end

    always_comb
    begin
        is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
        fval     = (fnum_reg == 2'd0) ? info_reg.f1_val : info_reg.f2_val;
        fbad     = (fnum_reg == 2'd0) ? info_reg.f1_bad : info_reg.f2_bad;
        nv       = {4'd0, fval} * 8'd10 + {4'd0, char_in[3:0]};
        rsum     = {hex_reg[3:0], hex_val};
        t1       = 8'd0;
        t2       = 8'd0;
        if (info_reg.count == 3'd4)
        begin
            t1 = info_reg.chars[0];
        end
        else if (info_reg.count == 3'd5)
        begin
            t1 = info_reg.chars[0];
            t2 = info_reg.chars[1];
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        hex_next   = hex_reg;
        fnum_next  = fnum_reg;
        info_next  = info_reg;

        res_valid         = 1'b0;
        res.status        = ST_FRAMING;
        res.kind          = KIND_NONE;
        res.talker_first  = t1;
        res.talker_second = t2;
        res.computed_sum  = xor_reg;
        res.received_sum  = hex_reg;

        if (en)
        begin
            if (phase_reg == PH_IDLE || char_in == CH_DOLLAR)
            begin
                // a dollar inside a sentence closes it as bad framing
                res_valid = (phase_reg != PH_IDLE);
                if (char_in == CH_DOLLAR)
                begin
                    phase_next = PH_ADDR;
                    xor_next   = 8'd0;
                    hex_next   = 8'd0;
                    fnum_next  = 2'd0;
                    info_next  = '0;
                end
            end
            else if (char_in == CH_CR || char_in == CH_LF)
            begin
                res_valid  = 1'b1;
                phase_next = PH_IDLE;
            end
            else
            begin
                unique case (phase_reg)
                    PH_ADDR:
                    begin
                        if (char_in == CH_STAR)
                            phase_next = PH_HEX1;
                        else
                        begin
                            xor_next = xor_reg ^ char_in;
                            if (char_in == CH_COMMA)
                            begin
                                phase_next = PH_BODY;
                                fnum_next  = 2'd0;
                            end
                            else if (info_reg.count < 3'(ADDR_MAX))
                            begin
                                info_next.chars[info_reg.count] = char_in;
                                info_next.count = info_reg.count + 3'd1;
                            end
                            else
                                info_next.count = 3'(ADDR_MAX + 1);
                        end
                    end
                    PH_BODY:
                    begin
                        if (char_in == CH_STAR)
                            phase_next = PH_HEX1;
                        else
                        begin
                            xor_next = xor_reg ^ char_in;
                            if (char_in == CH_COMMA)
                            begin
                                if (fnum_reg < 2'd2)
                                    fnum_next = fnum_reg + 2'd1;
                            end
                            else if (fnum_reg == 2'd0)
                            begin
                                info_next.f1_set = 1'b1;
                                if (!is_digit)
                                    info_next.f1_bad = 1'b1;
                                else if (!fbad)
                                begin
                                    if (nv > 8'd15)
                                        info_next.f1_bad = 1'b1;
                                    else
                                        info_next.f1_val = nv[3:0];
                                end
                            end
                            else if (fnum_reg == 2'd1)
                            begin
                                info_next.f2_set = 1'b1;
                                if (!is_digit)
                                    info_next.f2_bad = 1'b1;
                                else if (!fbad)
                                begin
                                    if (nv > 8'd15)
                                        info_next.f2_bad = 1'b1;
                                    else
                                        info_next.f2_val = nv[3:0];
                                end
                            end
                        end
                    end
                    PH_HEX1:
                    begin
                        if (!hex_ok)
                        begin
                            res_valid  = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            hex_next   = {4'd0, hex_val};
                            phase_next = PH_HEX2;
                        end
                    end
                    PH_HEX2:
                    begin
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                        if (hex_ok)
                        begin
                            hex_next         = rsum;
                            res.received_sum = rsum;
                            if (rsum != xor_reg)
                                res.status = ST_MISMATCH;
                            else if (kind != KIND_NONE)
                            begin
                                res.status = ST_OK;
                                res.kind   = kind;
                            end
                            else
                                res.status = ST_UNKNOWN;
                        end
                    end
                    default:
                        phase_next = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            xor_reg   <= 8'd0;
            hex_reg   <= 8'd0;
            fnum_reg  <= 2'd0;
            info_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            hex_reg   <= hex_next;
            fnum_reg  <= fnum_next;
            info_reg  <= info_next;
        end
    end

endmodule

>>> hw/rtl/nmea_sentence_checker.sv
// Channel   Dir  Width  Payload (lowest bit first)
// s_axis    in   8      char_in[7:0]
// m_axis    out  40     status, sentence_kind, talker_first, talker_second,
//                       computed_sum, received_sum, 2 zero pad bits
//
// One byte beat per cycle sustained while m_axis does not stall; the parser handles each
// byte in a single step between the input register and the result register.
// The byte beat that closes a sentence is held in the input register and its report in the
// result register, which drives m_axis; bytes that close nothing only advance the parser state.
// rst_n clears the parser to idle (waiting for a dollar sign) and empties
// both registers. A stalled report holds in the result register; the input
// register then holds one byte and s_tready drops until m_tready returns.
module nmea_sentence_checker
    import nsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // char_in[7:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status[1:0], sentence_kind[5:2], talker_first[13:6], talker_second[21:14],
    // computed_sum[29:22], received_sum[37:30], zero pad[39:38]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;
    logic        advance;
    logic        res_valid;
    result_t     res;

    // Advance the held byte into the parser whenever the result slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    nsc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .char_in   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = res_valid;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on a beat or when the parser advances with a result
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (advance && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.received_sum, out_reg.computed_sum,
                       out_reg.talker_second, out_reg.talker_first,
                       out_reg.kind, out_reg.status};

endmodule

>>> hw/rtl/nsc_checker.sv
module nsc_checker
    import nsc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic [1:0] st;
    logic [3:0] kd;
    logic [7:0] cs;
    logic [7:0] rs;

    assign st = m_tdata[1:0];
    assign kd = m_tdata[5:2];
    assign cs = m_tdata[29:22];
    assign rs = m_tdata[37:30];

    // A stalled report holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("report changed while stalled");

    // A good report names a known kind and matching sums
    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st == ST_OK |-> kd != KIND_NONE && cs == rs)
        else $error("ok report without kind or with differing sums");

    // Any other status carries no kind
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st != ST_OK |-> kd == KIND_NONE)
        else $error("kind reported on a failed sentence");

    // Mismatch means the sums differ, unknown type means they agree
    a_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (st == ST_MISMATCH || st == ST_UNKNOWN)
        |-> (cs != rs) == (st == ST_MISMATCH))
        else $error("sum compare disagrees with status");

    // An input stall with nothing in flight on the output is not allowed
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input held off with an empty result slot");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (.*);
